/* sv/vdi_pkg.sv */
// shared types and constants for the vertex dedup indexer
// no dependencies; used by every module of the block
package vdi_pkg;

    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int WORD_W            = 32;
    localparam int KEY_W             = 2 * WORD_W;
    localparam int INDEX_W           = 10;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // one vertex as four 64-bit keys, first word in the upper half
    typedef struct packed {
        logic [KEY_W-1:0] pos_xy;
        logic [KEY_W-1:0] pos_z_tex_u;
        logic [KEY_W-1:0] tex_v_norm_x;
        logic [KEY_W-1:0] norm_yz;
    } key_t;

endpackage

/* sv/vdi_key_store.sv */
// key store: four single-port-write, single-port-read key memories
// depends on vdi_pkg (key_t, KEY_W)
module vdi_key_store #(
    parameter int TABLE_ENTRIES = vdi_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  vdi_pkg::key_t     wr_key,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output vdi_pkg::key_t     rd_key
);

    logic [vdi_pkg::KEY_W-1:0] key_pos_xy       [TABLE_ENTRIES];
    logic [vdi_pkg::KEY_W-1:0] key_pos_z_tex_u  [TABLE_ENTRIES];
    logic [vdi_pkg::KEY_W-1:0] key_tex_v_norm_x [TABLE_ENTRIES];
    logic [vdi_pkg::KEY_W-1:0] key_norm_yz      [TABLE_ENTRIES];

    vdi_pkg::key_t rd_key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_pos_xy[wr_addr]       <= wr_key.pos_xy;
            key_pos_z_tex_u[wr_addr]  <= wr_key.pos_z_tex_u;
            key_tex_v_norm_x[wr_addr] <= wr_key.tex_v_norm_x;
            key_norm_yz[wr_addr]      <= wr_key.norm_yz;
        end
        if (rd_en)
        begin
            rd_key_reg.pos_xy       <= key_pos_xy[rd_addr];
            rd_key_reg.pos_z_tex_u  <= key_pos_z_tex_u[rd_addr];
            rd_key_reg.tex_v_norm_x <= key_tex_v_norm_x[rd_addr];
            rd_key_reg.norm_yz      <= key_norm_yz[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;

endmodule

/* sv/vdi_cmp_unit.sv */
// shared compare unit: bit-exact equality of a probe vertex and a stored entry
// depends on vdi_pkg (key_t)
module vdi_cmp_unit (
    input  vdi_pkg::key_t probe,
    input  vdi_pkg::key_t entry,
    output logic          match
);

    logic [3:0] key_eq;

    // raw bit compare, so +0/-0 differ and equal NaN patterns match
    assign key_eq[0] = (probe.pos_xy       == entry.pos_xy);
    assign key_eq[1] = (probe.pos_z_tex_u  == entry.pos_z_tex_u);
    assign key_eq[2] = (probe.tex_v_norm_x == entry.tex_v_norm_x);
    assign key_eq[3] = (probe.norm_yz      == entry.norm_yz);

    assign match = &key_eq;

endmodule

/* sv/vertex_dedup_indexer.sv */
// vertex dedup indexer: linear scan of the key store, one entry per cycle
// out_valid rises after the scan hits the matching entry for a found vertex, and after
// every stored entry has been read and compared for a new or rejected vertex
// in_stall holds off the next request until out_valid rises; a held result delays it
// reset: entry count cleared to zero, key store contents left undefined, no clearing pass
// depends on vdi_pkg, vdi_key_store, vdi_cmp_unit
module vertex_dedup_indexer #(
    parameter int TABLE_ENTRIES = vdi_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          start_mesh,
    input  logic [vdi_pkg::WORD_W-1:0]    pos_x,
    input  logic [vdi_pkg::WORD_W-1:0]    pos_y,
    input  logic [vdi_pkg::WORD_W-1:0]    pos_z,
    input  logic [vdi_pkg::WORD_W-1:0]    tex_u,
    input  logic [vdi_pkg::WORD_W-1:0]    tex_v,
    input  logic [vdi_pkg::WORD_W-1:0]    norm_x,
    input  logic [vdi_pkg::WORD_W-1:0]    norm_y,
    input  logic [vdi_pkg::WORD_W-1:0]    norm_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vdi_pkg::INDEX_W-1:0]   vertex_index,
    output logic [1:0]                    status
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_W = vdi_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    vdi_pkg::status_t    res_st_reg, res_st_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_idx_reg, out_idx_next;
    vdi_pkg::status_t    out_st_reg, out_st_next;
    vdi_pkg::key_t       key_reg, key_next;

    logic                rd_en;
    logic                wr_en;
    vdi_pkg::key_t       rd_key;
    logic                match;
    logic                hit;
    logic                accept;

    vdi_key_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_key_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_key  (key_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_key  (rd_key)
    );

    vdi_cmp_unit u_cmp_unit (
        .probe (key_reg),
        .entry (rd_key),
        .match (match)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && (state_reg == S_IDLE);
    assign hit          = rd_pend_reg && match;
    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign status       = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        out_idx_next   = out_idx_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && out_stall;
        key_next       = key_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next.pos_xy       = {pos_x, pos_y};
                    key_next.pos_z_tex_u  = {pos_z, tex_u};
                    key_next.tex_v_norm_x = {tex_v, norm_x};
                    key_next.norm_yz      = {norm_y, norm_z};
                    if (start_mesh)
                    begin
                        count_next = '0;
                    end
                    scan_idx_next = '0;
                    rd_pend_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_pend_next = 1'b0;
                if (hit)
                begin
                    res_idx_next = rd_idx_reg;
                    res_st_next  = vdi_pkg::ST_FOUND;
                    state_next   = S_DONE;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    // read entry now, compare it next cycle
                    rd_en         = 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
                end
                else if (!rd_pend_reg)
                begin
                    // scan exhausted with no match
                    if (count_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        res_idx_next = '0;
                        res_st_next  = vdi_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        res_idx_next = count_reg[IDX_W-1:0];
                        res_st_next  = vdi_pkg::ST_NEW;
                        count_next   = CNT_W'(count_reg + 1'b1);
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = OUT_W'(res_idx_reg);
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            res_idx_reg   <= '0;
            res_st_reg    <= vdi_pkg::ST_FOUND;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_st_reg    <= vdi_pkg::ST_FOUND;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            res_idx_reg   <= res_idx_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_st_reg    <= out_st_next;
        end
    end

    // request payload, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
